### hdl/pdr_pkg.sv
// Shared types, constants and register indexes for the point depth rasterizer.
`default_nettype none
package pdr_pkg;
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int DEPTH_W = 48;
  localparam int COUNT_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd6;

  localparam logic [1:0] MODE_NEAREST  = 2'd0;
  localparam logic [1:0] MODE_FARTHEST = 2'd1;
  localparam logic [1:0] MODE_SUM      = 2'd2;
  localparam logic [1:0] MODE_AVERAGE  = 2'd3;

  localparam logic CMD_PROJECT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] x_cam;
    logic [31:0] y_cam;
    logic [31:0] z_cam;
    logic [8:0]  read_col;
    logic [8:0]  read_row;
  } in_item_t;

  typedef struct packed {
    logic         in_frame;
    logic [8:0]   pixel_col;
    logic [8:0]   pixel_row;
    logic [47:0]  depth_value;
    logic [7:0]   hit_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic mul;       // register products
    logic sum;       // register Q32.32 sums
    logic idx;       // pixel index and bounds
    logic rd;        // issue memory read
    logic merge;     // compute merged value
    logic wr;        // write back
    logic div_start;
    logic div_step;
    logic fin;       // build result
    logic clr_step;
  } pdr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic div_needed;
    logic div_done;
    logic clr_done;
  } pdr_stat_t;
endpackage
`default_nettype wire

### hdl/pdr_if.sv
// Valid/ready channel interfaces for items and configuration writes.
`default_nettype none
interface pdr_in_if;
  logic valid;
  logic ready;
  pdr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdr_out_if;
  logic valid;
  logic ready;
  pdr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdr_cfg_if;
  logic valid;
  logic ready;
  logic [pdr_pkg::CFG_IDX_W-1:0]  index;
  logic [pdr_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### hdl/pdr_ctrl.sv
// Sequencer for projection, read-modify-write, divide and clearing pass.
`default_nettype none
module pdr_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_fire,
  input  wire pdr_pkg::pdr_stat_t stat,
  output logic in_ready,
  output logic out_valid,
  output pdr_pkg::pdr_cmd_t cmd
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SUM, S_IDX, S_RD, S_MERGE, S_WR, S_DIV, S_FIN, S_OUT
  } state_t;
  state_t state;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    case (state)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_MUL:   cmd.mul = 1'b1;
      S_SUM:   cmd.sum = 1'b1;
      S_IDX:   cmd.idx = 1'b1;
      S_RD:    cmd.rd = 1'b1;
      S_MERGE: begin
        cmd.merge = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_WR:    cmd.wr = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_FIN:   cmd.fin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      in_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: if (stat.clr_done) begin
          state <= S_IDLE;
          in_ready <= 1'b1;
        end
        S_IDLE: if (in_fire) begin
          in_ready <= 1'b0;
          state <= S_MUL;
        end
        S_MUL:   state <= S_SUM;
        S_SUM:   state <= S_IDX;
        S_IDX:   state <= S_RD;
        S_RD:    state <= S_MERGE;
        S_MERGE: state <= S_WR;
        S_WR:    state <= (stat.is_read && stat.div_needed) ? S_DIV : S_FIN;
        S_DIV:   if (stat.div_done) state <= S_FIN;
        S_FIN: begin
          state <= S_OUT;
          out_valid <= 1'b1;
        end
        S_OUT: if (out_fire) begin
          out_valid <= 1'b0;
          in_ready <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/pdr_datapath.sv
// Projection arithmetic, pixel stores, merge logic and serial divider.
`default_nettype none
module pdr_datapath #(
  parameter int MAX_WIDTH  = pdr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pdr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pdr_pkg::pdr_cmd_t cmd,
  input  wire pdr_pkg::in_item_t in_data,
  input  wire logic [31:0] scale_x,
  input  wire logic [31:0] scale_y,
  input  wire logic [26:0] center_col,
  input  wire logic [26:0] center_row,
  input  wire logic [9:0]  width_in_use,
  input  wire logic [9:0]  height_in_use,
  input  wire logic [1:0]  render_mode,
  output pdr_pkg::pdr_stat_t stat,
  output pdr_pkg::out_item_t out_data
);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int SW = 13; // frame size width, holds 4096
  localparam logic [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  logic [47:0] depth_mem [PIXELS];
  logic [7:0]  count_mem [PIXELS];

  pdr_pkg::in_item_t req;
  logic signed [63:0] px, pcx, py, pcy;
  logic signed [64:0] scol, srow;
  logic col_ok, row_ok, hit;
  logic [8:0] col_o, row_o;
  logic [AW-1:0] addr, clr_addr;
  logic [47:0] cur;
  logic [7:0]  cur_cnt;
  logic [47:0] new_val;
  logic [7:0]  new_cnt;
  logic        do_wr;
  // divider
  logic [47:0] dq, drem_n;
  logic [8:0]  drem;
  logic [5:0]  dcnt;
  logic        dneg;
  logic [47:0] result_val;

  logic [SW-1:0] fw, fh;
  assign fw = (SW'(width_in_use) < SW'(MAX_WIDTH)) ? SW'(width_in_use) : SW'(MAX_WIDTH);
  assign fh = (SW'(height_in_use) < SW'(MAX_HEIGHT)) ? SW'(height_in_use) : SW'(MAX_HEIGHT);

  // Q32.32 sum to index; returns ok in bit 33, magnitude quotient below
  function automatic logic [33:0] to_pix(input logic signed [64:0] s, input logic trunc,
                                         input logic [SW-1:0] lim);
    logic [64:0] m;
    logic [32:0] q;
    logic ok;
    m = s[64] ? (65'd0 - s) : s;
    q = trunc ? m[64:32] : 33'((m + 65'h80000000) >> 32);
    if (s > 65'sh7FFF_FFFF_FFFF_FFFF || s < -65'sh8000_0000_0000_0000) ok = 1'b0;
    else if (q == 33'd0) ok = (lim != '0);
    else ok = !s[64] && (q < 33'(lim));
    return {ok, q};
  endfunction

  logic [33:0] tc, tr;
  logic trunc;
  assign trunc = (render_mode == pdr_pkg::MODE_AVERAGE);
  assign tc = to_pix(scol, trunc, fw);
  assign tr = to_pix(srow, trunc, fh);

  logic signed [48:0] zsum;
  logic signed [47:0] z48;
  assign z48 = 48'(signed'(req.z_cam));
  assign zsum = 49'(signed'(cur)) + 49'(z48);

  assign drem_n = 48'({drem[7:0], dq[47]});

  always_ff @(posedge clk) begin
    if (cmd.load) req <= in_data;
    if (cmd.mul) begin
      px  <= signed'(req.x_cam) * signed'({1'b0, scale_x});
      pcx <= signed'(req.z_cam) * signed'({1'b0, center_col});
      py  <= signed'(req.y_cam) * signed'({1'b0, scale_y});
      pcy <= signed'(req.z_cam) * signed'({1'b0, center_row});
    end
    if (cmd.sum) begin
      scol <= 65'(px) + 65'(pcx);
      srow <= 65'(py) + 65'(pcy);
    end
    if (cmd.idx) begin
      if (req.cmd == pdr_pkg::CMD_READ) begin
        col_o <= req.read_col;
        row_o <= req.read_row;
        hit <= (SW'(req.read_col) < fw) && (SW'(req.read_row) < fh);
        addr <= AW'(req.read_row * MAX_WIDTH + req.read_col);
      end else begin
        hit <= tc[33] && tr[33];
        col_o <= (tc[33] && tr[33]) ? tc[8:0] : 9'd0;
        row_o <= (tc[33] && tr[33]) ? tr[8:0] : 9'd0;
        addr <= AW'(tr[RW-1:0] * MAX_WIDTH + tc[CW-1:0]);
      end
    end
    if (cmd.rd) begin
      cur <= depth_mem[addr];
      cur_cnt <= count_mem[addr];
    end
    if (cmd.merge) begin
      do_wr <= hit;
      if (req.cmd == pdr_pkg::CMD_READ) begin
        new_val <= '0;
        new_cnt <= '0;
      end else begin
        new_cnt <= (cur_cnt == 8'hFF) ? cur_cnt : cur_cnt + 8'd1;
        case (render_mode)
          pdr_pkg::MODE_NEAREST:
            new_val <= (cur == '0 || signed'(z48) < signed'(cur)) ? z48 : cur;
          pdr_pkg::MODE_FARTHEST:
            new_val <= (cur == '0 || signed'(z48) > signed'(cur)) ? z48 : cur;
          default:
            if (zsum > 49'(signed'(SUM_MAX))) new_val <= SUM_MAX;
            else if (zsum < 49'(signed'(SUM_MIN))) new_val <= SUM_MIN;
            else new_val <= zsum[47:0];
        endcase
      end
    end
    if (cmd.wr && do_wr) begin
      depth_mem[addr] <= new_val;
      count_mem[addr] <= new_cnt;
    end
    if (cmd.clr_step) begin
      depth_mem[clr_addr] <= '0;
      count_mem[clr_addr] <= '0;
    end
    if (cmd.div_start) begin
      dneg <= cur[47];
      dq <= cur[47] ? (48'd0 - cur) : cur;
      drem <= '0;
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      // restoring division, one quotient bit a cycle
      if ({1'b0, drem_n[8:0]} >= {2'b0, cur_cnt}) begin
        drem <= 9'(drem_n[8:0] - {1'b0, cur_cnt});
        dq <= {dq[46:0], 1'b1};
      end else begin
        drem <= drem_n[8:0];
        dq <= {dq[46:0], 1'b0};
      end
      dcnt <= dcnt + 6'd1;
    end
    if (cmd.fin) begin
      out_data.in_frame <= hit;
      out_data.pixel_col <= col_o;
      out_data.pixel_row <= row_o;
      out_data.depth_value <= (req.cmd == pdr_pkg::CMD_READ && hit) ? result_val : '0;
      out_data.hit_count <= (req.cmd == pdr_pkg::CMD_READ && hit) ? cur_cnt : '0;
    end
  end

  always_comb begin
    if (render_mode != pdr_pkg::MODE_AVERAGE) result_val = cur;
    else if (cur_cnt == '0) result_val = '0;
    else result_val = dneg ? (48'd0 - dq) : dq;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + AW'(1);
  end

  assign stat.is_read = (req.cmd == pdr_pkg::CMD_READ);
  assign stat.div_needed = hit && (render_mode == pdr_pkg::MODE_AVERAGE) && (cur_cnt != '0);
  assign stat.div_done = (dcnt == 6'd47) && cmd.div_step;
  assign stat.clr_done = (clr_addr == AW'(PIXELS - 1)) && cmd.clr_step;
endmodule
`default_nettype wire

### hdl/pdr_cfg_regs.sv
// Configuration register file.
`default_nettype none
module pdr_cfg_regs (
  input  wire logic clk,
  input  wire logic rst,
  pdr_cfg_if.sink cfg,
  output logic [31:0] scale_x,
  output logic [31:0] scale_y,
  output logic [26:0] center_col,
  output logic [26:0] center_row,
  output logic [9:0]  width_in_use,
  output logic [9:0]  height_in_use,
  output logic [1:0]  render_mode
);
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= 32'd65536;
      scale_y <= 32'd65536;
      center_col <= '0;
      center_row <= '0;
      width_in_use <= 10'd512;
      height_in_use <= 10'd512;
      render_mode <= pdr_pkg::MODE_NEAREST;
    end else if (cfg.valid) begin
      case (cfg.index)
        pdr_pkg::REG_SCALE_X:    scale_x <= cfg.wdata;
        pdr_pkg::REG_SCALE_Y:    scale_y <= cfg.wdata;
        pdr_pkg::REG_CENTER_COL: center_col <= cfg.wdata[26:0];
        pdr_pkg::REG_CENTER_ROW: center_row <= cfg.wdata[26:0];
        pdr_pkg::REG_WIDTH:      width_in_use <= cfg.wdata[9:0];
        pdr_pkg::REG_HEIGHT:     height_in_use <= cfg.wdata[9:0];
        pdr_pkg::REG_MODE:       render_mode <= cfg.wdata[1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### hdl/point_depth_rasterizer.sv
// Point depth rasterizer top level.
// Each request is multiplied, summed, indexed, read, merged, written back and
// finished, and an average-mode read of a hit pixel also divides. One request at a
// time, set by the sequencer walking a single-port read-modify-write and a bit-serial
// 48-step divider. Reset: clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels
// (262144 at default) with input ready low; configuration writes are taken throughout.
`default_nettype none
module point_depth_rasterizer #(
  parameter int MAX_WIDTH  = pdr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pdr_pkg::MAX_HEIGHT_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pdr_in_if.sink   in_ch,
  pdr_out_if.source out_ch,
  pdr_cfg_if.sink  cfg
);
  logic [31:0] scale_x, scale_y;
  logic [26:0] center_col, center_row;
  logic [9:0]  width_in_use, height_in_use;
  logic [1:0]  render_mode;
  pdr_pkg::pdr_cmd_t cmd;
  pdr_pkg::pdr_stat_t stat;
  logic in_ready, out_valid;

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;

  pdr_cfg_regs u_cfg (
    .clk, .rst, .cfg,
    .scale_x, .scale_y, .center_col, .center_row,
    .width_in_use, .height_in_use, .render_mode
  );

  pdr_ctrl u_ctrl (
    .clk, .rst,
    .in_fire(in_ch.valid && in_ready),
    .out_fire(out_valid && out_ch.ready),
    .stat, .in_ready, .out_valid, .cmd
  );

  pdr_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk, .rst, .cmd,
    .in_data(in_ch.data),
    .scale_x, .scale_y, .center_col, .center_row,
    .width_in_use, .height_in_use, .render_mode,
    .stat, .out_data(out_ch.data)
  );
endmodule
`default_nettype wire

### tb/tb_pdr_checker.sv
// Scoreboard for the point depth rasterizer: pixel store prediction and result compare.
`timescale 1ns / 1ps
module tb_pdr_checker (
  input  logic        clk,
  input  logic        rst,
  pdr_in_if           in_ch,
  pdr_out_if          out_ch,
  pdr_cfg_if          cfg,
  output int unsigned fail_count,
  output int unsigned outstanding
);
  localparam int GRID_W = pdr_pkg::MAX_WIDTH_DEF;
  localparam int GRID_H = pdr_pkg::MAX_HEIGHT_DEF;
  localparam logic signed [65:0] FIX_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] FIX_MIN = -66'sh0_8000_0000_0000_0000;
  localparam logic signed [48:0] DEPTH_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] DEPTH_MIN = -49'sh0_8000_0000_0000;

  logic [31:0] scale_x, scale_y;
  logic [26:0] center_col, center_row;
  logic [9:0]  width_in_use, height_in_use;
  logic [1:0]  render_mode;

  // sparse pixel stores; a missing entry reads as zero
  logic signed [47:0] depth_mem [int];
  logic [7:0]         hits_mem [int];

  pdr_pkg::out_item_t pixel_results_q [$];
  int unsigned errors = 0;
  int unsigned pending = 0;

  assign fail_count  = errors;
  assign outstanding = pending;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Q32.32 sum to pixel index; 0 when the point falls outside this axis
  function automatic logic map_axis(input logic signed [63:0] a, input logic signed [63:0] b,
                                    input logic trunc, input int unsigned lim,
                                    output logic [8:0] pix);
    logic signed [65:0] s;
    logic [65:0] m, q;
    pix = '0;
    s = {{2{a[63]}}, a} + {{2{b[63]}}, b};
    if (s > FIX_MAX || s < FIX_MIN) return 1'b0;
    m = (s < 0) ? -s : s;
    q = trunc ? (m >> 32) : ((m + 66'h8000_0000) >> 32);
    if (q == 0) return lim > 0;
    if (s < 0 || q >= lim) return 1'b0;
    pix = q[8:0];
    return 1'b1;
  endfunction

  function automatic pdr_pkg::out_item_t project_or_read(input pdr_pkg::in_item_t r);
    pdr_pkg::out_item_t res;
    int unsigned fw, fh;
    int key;
    logic signed [47:0] cur, zs;
    logic signed [48:0] acc;
    logic [7:0] cnt;
    longint ax, az, by, bz, q;
    logic [8:0] col, row;
    logic hit;
    res = '0;
    fw = (width_in_use < GRID_W) ? width_in_use : GRID_W;
    fh = (height_in_use < GRID_H) ? height_in_use : GRID_H;
    if (r.cmd == pdr_pkg::CMD_READ) begin
      res.pixel_col = r.read_col;
      res.pixel_row = r.read_row;
      if (r.read_col >= fw || r.read_row >= fh) return res;
      key = r.read_row * GRID_W + r.read_col;
      cur = depth_mem.exists(key) ? depth_mem[key] : '0;
      cnt = hits_mem.exists(key) ? hits_mem[key] : '0;
      if (render_mode == pdr_pkg::MODE_AVERAGE) begin
        if (cnt == 0) begin
          cur = '0;
        end else begin
          q = longint'(cur) / longint'(cnt);
          cur = q[47:0];
        end
      end
      depth_mem.delete(key);
      hits_mem.delete(key);
      res.in_frame    = 1'b1;
      res.depth_value = cur;
      res.hit_count   = cnt;
      return res;
    end
    ax = longint'(signed'(r.x_cam)) * longint'(scale_x);
    az = longint'(signed'(r.z_cam)) * longint'(center_col);
    by = longint'(signed'(r.y_cam)) * longint'(scale_y);
    bz = longint'(signed'(r.z_cam)) * longint'(center_row);
    hit = map_axis(ax, az, render_mode == pdr_pkg::MODE_AVERAGE, fw, col);
    if (hit) hit = map_axis(by, bz, render_mode == pdr_pkg::MODE_AVERAGE, fh, row);
    if (!hit) return res;
    key = row * GRID_W + col;
    cur = depth_mem.exists(key) ? depth_mem[key] : '0;
    cnt = hits_mem.exists(key) ? hits_mem[key] : '0;
    zs = {{16{r.z_cam[31]}}, r.z_cam};
    case (render_mode)
      pdr_pkg::MODE_NEAREST: begin
        if (cur == 0 || zs < cur) cur = zs;
      end
      pdr_pkg::MODE_FARTHEST: begin
        if (cur == 0 || zs > cur) cur = zs;
      end
      default: begin
        acc = {cur[47], cur} + {zs[47], zs};
        if (acc > DEPTH_MAX) acc = DEPTH_MAX;
        if (acc < DEPTH_MIN) acc = DEPTH_MIN;
        cur = acc[47:0];
      end
    endcase
    depth_mem[key] = cur;
    hits_mem[key]  = (cnt == 8'hFF) ? cnt : cnt + 8'd1;
    res.in_frame  = 1'b1;
    res.pixel_col = col;
    res.pixel_row = row;
    return res;
  endfunction

  always @(posedge clk) begin
    pdr_pkg::out_item_t want, got;
    if (rst) begin
      scale_x       = 32'h0001_0000;
      scale_y       = 32'h0001_0000;
      center_col    = '0;
      center_row    = '0;
      width_in_use  = 10'd512;
      height_in_use = 10'd512;
      render_mode   = pdr_pkg::MODE_NEAREST;
      depth_mem.delete();
      hits_mem.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          pdr_pkg::REG_SCALE_X:    scale_x = cfg.wdata;
          pdr_pkg::REG_SCALE_Y:    scale_y = cfg.wdata;
          pdr_pkg::REG_CENTER_COL: center_col = cfg.wdata[26:0];
          pdr_pkg::REG_CENTER_ROW: center_row = cfg.wdata[26:0];
          pdr_pkg::REG_WIDTH:      width_in_use = cfg.wdata[9:0];
          pdr_pkg::REG_HEIGHT:     height_in_use = cfg.wdata[9:0];
          pdr_pkg::REG_MODE:       render_mode = cfg.wdata[1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) pixel_results_q.push_back(project_or_read(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pixel_results_q.size() == 0) begin
          report($sformatf("unexpected result %p", got));
        end else begin
          want = pixel_results_q.pop_front();
          if (got.in_frame != want.in_frame)
            report($sformatf("in_frame %0b, want %0b", got.in_frame, want.in_frame));
          if (got.pixel_col != want.pixel_col)
            report($sformatf("pixel_col %0d, want %0d", got.pixel_col, want.pixel_col));
          if (got.pixel_row != want.pixel_row)
            report($sformatf("pixel_row %0d, want %0d", got.pixel_row, want.pixel_row));
          if (got.depth_value != want.depth_value)
            report($sformatf("depth_value %h, want %h", got.depth_value, want.depth_value));
          if (got.hit_count != want.hit_count)
            report($sformatf("hit_count %0d, want %0d", got.hit_count, want.hit_count));
        end
      end
      pending <= pixel_results_q.size();
    end
  end
endmodule

### tb/tb_point_depth_rasterizer.sv
// Stimulus and verdict for the point depth rasterizer.
`timescale 1ns / 1ps
module tb_point_depth_rasterizer;
  localparam int WATCHDOG_LIMIT = 1500000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int NUM_PHASES     = 7;

  typedef struct {
    logic [31:0] sx, sy;
    logic [26:0] cc, cr;
    logic [9:0]  w, h;
    logic [1:0]  mode;
    int          n_items;
    int          read_pct;
  } phase_t;

  logic clk, rst;
  int unsigned fail_count, outstanding;
  int unsigned n_points = 0, n_reads = 0, idle_cycles = 0;
  int burst_left = 1;
  int stall_span = 0, stall_style = 0;
  phase_t phases [NUM_PHASES];
  phase_t cur;

  pdr_in_if  in_ch ();
  pdr_out_if out_ch ();
  pdr_cfg_if cfg_ch ();

  point_depth_rasterizer u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  tb_pdr_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: stretches of full rate, light stalls and heavy stalls
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span  = $urandom_range(20, 300);
      stall_style = $urandom_range(0, 2);
    end
    stall_span--;
    case (stall_style)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[point_depth_rasterizer] ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [pdr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_request(input pdr_pkg::in_item_t r);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    if (r.cmd == pdr_pkg::CMD_READ) n_reads++;
    else n_points++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // hold until every request has its result, then let any late work settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic pdr_pkg::in_item_t point_req(input logic [31:0] x, input logic [31:0] y,
                                                  input logic [31:0] z);
    pdr_pkg::in_item_t r;
    r = '0;
    r.cmd   = pdr_pkg::CMD_PROJECT;
    r.x_cam = x;
    r.y_cam = y;
    r.z_cam = z;
    return r;
  endfunction

  function automatic pdr_pkg::in_item_t read_req(input int c, input int rw);
    pdr_pkg::in_item_t r;
    r.cmd      = pdr_pkg::CMD_READ;
    r.x_cam    = $urandom;
    r.y_cam    = $urandom;
    r.z_cam    = $urandom;
    r.read_col = c[8:0];
    r.read_row = rw[8:0];
    return r;
  endfunction

  // mostly a small corner of the frame so pixels collect several hits
  function automatic int pick_coord(input int lim);
    int span, k;
    span = (lim == 0) ? 1 : lim;
    k = $urandom_range(0, 9);
    if (k < 7) return $urandom_range(0, ((span < 6) ? span : 6) - 1);
    if (k < 9) return $urandom_range(0, span - 1);
    return $urandom_range(0, 511);
  endfunction

  // solve scale*v + center*z = target for v, with optional jitter around it
  function automatic logic [31:0] aim_axis(input int target, input logic [31:0] scale,
                                           input logic [26:0] center, input longint z);
    longint num, v;
    if (scale == 0) return $urandom;
    num = (longint'(target) <<< 32) - longint'(center) * z;
    v = num / longint'(scale);
    if ($urandom_range(0, 2) == 0) begin
      if (scale <= 32'h0002_0000) v += longint'($urandom_range(0, 32'h10000)) - 32'h8000;
      else v += longint'($urandom_range(0, 4)) - 2;
    end
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic pdr_pkg::in_item_t random_req(input phase_t p);
    int fw, fh, k;
    longint z;
    fw = (p.w < 512) ? p.w : 512;
    fh = (p.h < 512) ? p.h : 512;
    if ($urandom_range(0, 99) < p.read_pct) begin
      if ($urandom_range(0, 9) == 0) return read_req($urandom_range(0, 511), $urandom_range(0, 511));
      return read_req(pick_coord(fw), pick_coord(fh));
    end
    if ($urandom_range(0, 9) == 0) return point_req($urandom, $urandom, $urandom);
    k = $urandom_range(0, 9);
    if (k < 6) z = $urandom_range(32'h100, 32'h80000);
    else if (k < 8) z = -longint'($urandom_range(1, 32'h40000));
    else if (k == 8) z = 0;
    else z = longint'(signed'(32'($urandom)));
    return point_req(aim_axis(pick_coord(fw), p.sx, p.cc, z),
                     aim_axis(pick_coord(fh), p.sy, p.cr, z), z[31:0]);
  endfunction

  initial begin
    phases[0] = '{32'h0001_0000, 32'h0001_0000, 27'h0, 27'h0, 10'd16, 10'd16,
                  pdr_pkg::MODE_NEAREST, 300, 25};
    phases[1] = '{32'h0002_0000, 32'h0001_8000, 27'h4_0000, 27'h2_0000, 10'd32, 10'd24,
                  pdr_pkg::MODE_FARTHEST, 300, 25};
    phases[2] = '{32'h0000_8000, 32'h0001_0000, 27'h0, 27'h1_0000, 10'd512, 10'd512,
                  pdr_pkg::MODE_SUM, 300, 25};
    phases[3] = '{32'h0001_0000, 32'h0001_0000, 27'h7FF_FFFF, 27'h400_0000, 10'd512, 10'd512,
                  pdr_pkg::MODE_AVERAGE, 300, 25};
    // single pixel frame, rare reads: drive the hit count into saturation
    phases[4] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 27'h0, 27'h0, 10'd1, 10'd1,
                  pdr_pkg::MODE_AVERAGE, 300, 1};
    phases[5] = '{32'h0, 32'h0, 27'h1_0000, 27'h1_0000, 10'd1023, 10'd0,
                  pdr_pkg::MODE_NEAREST, 60, 30};
    phases[6] = '{32'h0001_0000, 32'h0001_0000, 27'h0, 27'h0, 10'd0, 10'd512,
                  pdr_pkg::MODE_SUM, 240, 30};

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests at reset settings: 512x512 frame, nearest, unit scale
    send_request(point_req(32'h0, 32'h0, 32'h0));
    send_request(point_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_request(point_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_request(point_req(32'hFFFF_999A, 32'h0, 32'h0001_0000));   // rounds up to column 0
    send_request(point_req(32'hFFFF_6666, 32'h0, 32'h0001_0000));   // rounds to -1, dropped
    send_request(point_req(32'h0000_8000, 32'h0000_8000, 32'h0002_0000));
    send_request(point_req(32'h01FF_6666, 32'h01FF_6666, 32'h0002_0000));
    send_request(point_req(32'h01FF_8000, 32'h0, 32'h0002_0000));   // column 512, dropped
    send_request(point_req(32'h0005_0000, 32'h0005_0000, 32'h0003_0000));
    send_request(point_req(32'h0005_0000, 32'h0005_0000, 32'h0001_0000));
    send_request(point_req(32'h0005_0000, 32'h0005_0000, 32'hFFFF_0000));
    send_request(point_req(32'h0005_0000, 32'h0005_0000, 32'h0004_0000));
    send_request(read_req(5, 5));
    send_request(read_req(5, 5));
    send_request(read_req(511, 511));
    send_request(read_req(1, 1));
    send_request(read_req(0, 0));
    send_request(read_req(511, 0));
    wait_idle();

    foreach (phases[i]) begin
      cur = phases[i];
      write_reg(pdr_pkg::REG_SCALE_X, cur.sx);
      write_reg(pdr_pkg::REG_SCALE_Y, cur.sy);
      write_reg(pdr_pkg::REG_CENTER_COL, {5'b0, cur.cc});
      write_reg(pdr_pkg::REG_CENTER_ROW, {5'b0, cur.cr});
      write_reg(pdr_pkg::REG_WIDTH, {22'b0, cur.w});
      write_reg(pdr_pkg::REG_HEIGHT, {22'b0, cur.h});
      write_reg(pdr_pkg::REG_MODE, {30'b0, cur.mode});
      repeat (cur.n_items) send_request(random_req(cur));
      // a one-column frame ends with a read of pixel (0,0), which clears it for the next setting
      if (cur.w == 10'd1) send_request(read_req(0, 0));
      wait_idle();
    end

    $display("run covered %0d point projections and %0d pixel reads", n_points, n_reads);
    $display("over %0d register settings, all four merge modes", NUM_PHASES + 1);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[point_depth_rasterizer] OK");
    end else begin
      $display("[point_depth_rasterizer] ERROR");
    end
    $finish;
  end
endmodule
